FILE: hdl/mbox_separator_line_classifier_macros.svh
// Assertion macros for the mbox separator line classifier.
// Used by the top level only; no other dependencies.
`ifndef MBOX_SEPARATOR_LINE_CLASSIFIER_MACROS_SVH
`define MBOX_SEPARATOR_LINE_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define MSLC_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: cond -> prop");
// Next-cycle implication.
`define MSLC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: cond => prop");
`else
`define MSLC_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define MSLC_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

FILE: hdl/mslc_pkg.sv
// Package for the mbox separator line classifier: byte codes, state encodings,
// step and result types and the pattern-matching functions. No dependencies.
package mslc_pkg;

    localparam logic [7:0] LF_BYTE = 8'h0A;
    localparam logic [7:0] CR_BYTE = 8'h0D;
    localparam logic [7:0] SP_BYTE = 8'h20;
    localparam logic [7:0] NUL_BYTE = 8'h00;

    localparam int SEP_W = 6;
    localparam int ESC_W = 3;

    // Separator match progress: 0 at line start, DONE once all but the line
    // feed has matched, FAIL after a mismatch.
    localparam logic [SEP_W-1:0] SEP_START = 6'd0;
    localparam logic [SEP_W-1:0] SEP_SENDER = 6'd5;
    localparam logic [SEP_W-1:0] SEP_IN_SENDER = 6'd6;
    localparam logic [SEP_W-1:0] SEP_SPACES = 6'd7;
    localparam logic [SEP_W-1:0] SEP_TAIL = 6'd8;
    localparam logic [SEP_W-1:0] SEP_DONE = 6'd31;
    localparam logic [SEP_W-1:0] SEP_FAIL = 6'd63;

    localparam logic [ESC_W-1:0] ESC_START = 3'd0;
    localparam logic [ESC_W-1:0] ESC_DONE = 3'd6;
    localparam logic [ESC_W-1:0] ESC_FAIL = 3'd7;

    typedef enum logic [2:0] {
        CLS_UPPER   = 3'd1,
        CLS_LOWER   = 3'd2,
        CLS_SPACE   = 3'd3,
        CLS_DIGIT   = 3'd4,
        CLS_SPDIGIT = 3'd5,
        CLS_COLON   = 3'd6
    } t_char_class;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_step;

    typedef struct packed {
        logic escaped_from;
        logic new_message;
        logic is_separator;
    } t_result;

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Characters of "From ".
    function automatic logic [7:0] from_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0: ch = 8'h46;
            3'd1: ch = 8'h72;
            3'd2: ch = 8'h6F;
            3'd3: ch = 8'h6D;
            default: ch = SP_BYTE;
        endcase
        return ch;
    endfunction

    // Characters of ">From ".
    function automatic logic [7:0] esc_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0: ch = 8'h3E;
            3'd1: ch = 8'h46;
            3'd2: ch = 8'h72;
            3'd3: ch = 8'h6F;
            3'd4: ch = 8'h6D;
            default: ch = SP_BYTE;
        endcase
        return ch;
    endfunction

    // Fixed tail of the separator: rest of two names, day, time and year.
    function automatic t_char_class tail_class(input logic [4:0] idx);
        t_char_class k;
        unique case (idx)
            5'd0, 5'd1, 5'd4, 5'd5:           k = CLS_LOWER;
            5'd2, 5'd6, 5'd9, 5'd18:          k = CLS_SPACE;
            5'd3:                             k = CLS_UPPER;
            5'd7, 5'd10:                      k = CLS_SPDIGIT;
            5'd12, 5'd15:                     k = CLS_COLON;
            default:                          k = CLS_DIGIT;
        endcase
        return k;
    endfunction

    function automatic logic class_ok(input t_char_class k, input logic [7:0] c);
        logic ok;
        unique case (k)
            CLS_UPPER:   ok = is_upper(c);
            CLS_LOWER:   ok = is_lower(c);
            CLS_SPACE:   ok = (c == SP_BYTE);
            CLS_DIGIT:   ok = is_digit(c);
            CLS_SPDIGIT: ok = (c == SP_BYTE) || is_digit(c);
            CLS_COLON:   ok = (c == 8'h3A);
            default:     ok = 1'b0;
        endcase
        return ok;
    endfunction

    // Next separator position for a byte that is not a line feed.
    function automatic logic [SEP_W-1:0] sep_next(input logic [SEP_W-1:0] pos,
                                                  input logic [7:0] c);
        logic [SEP_W-1:0] nxt;
        logic [4:0]       tidx;
        tidx = pos[4:0] - SEP_TAIL[4:0];
        nxt = SEP_FAIL;
        priority if (pos < SEP_SENDER) begin
            if (c == from_char(pos[2:0])) nxt = pos + 6'd1;
        end else if (pos == SEP_SENDER) begin
            if (c != SP_BYTE && c != NUL_BYTE) nxt = SEP_IN_SENDER;
        end else if (pos == SEP_IN_SENDER) begin
            if (c == SP_BYTE) nxt = SEP_SPACES;
            else if (c != NUL_BYTE) nxt = SEP_IN_SENDER;
        end else if (pos == SEP_SPACES) begin
            if (c == SP_BYTE) nxt = SEP_SPACES;
            else if (is_upper(c)) nxt = SEP_TAIL;
        end else if (pos < SEP_DONE) begin
            if (class_ok(tail_class(tidx), c)) nxt = pos + 6'd1;
        end else begin
            nxt = SEP_FAIL;
        end
        return nxt;
    endfunction

    function automatic logic [ESC_W-1:0] esc_next(input logic [ESC_W-1:0] pos,
                                                  input logic [7:0] c);
        logic [ESC_W-1:0] nxt;
        nxt = pos;
        if (pos < ESC_DONE) nxt = (c == esc_char(pos)) ? pos + 3'd1 : ESC_FAIL;
        return nxt;
    endfunction

endpackage

FILE: hdl/mslc_line_matcher.sv
// Line state and per-byte match logic of the mbox separator line classifier.
// Depends on mslc_pkg.
module mslc_line_matcher
    import mslc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_step   i_step,
    input  logic    i_fire,
    output logic    o_produce,
    output t_result o_result
);

    logic [SEP_W-1:0] r_match, n_match;
    logic [ESC_W-1:0] r_esc, n_esc;
    logic             r_seen, n_seen;
    logic             r_pending, n_pending;
    logic             by_feed;

    always_comb begin
        n_match   = r_match;
        n_esc     = r_esc;
        n_seen    = r_seen;
        n_pending = 1'b0;
        by_feed   = (i_step.data == LF_BYTE);
        o_produce = by_feed || i_step.last;

        // A held carriage return is a plain character unless a line feed follows.
        if (r_pending && !by_feed) begin
            n_match = sep_next(n_match, CR_BYTE);
            n_esc   = esc_next(n_esc, CR_BYTE);
        end

        if (i_step.data == CR_BYTE) begin
            if (i_step.last) begin
                n_match = sep_next(n_match, CR_BYTE);
                n_esc   = esc_next(n_esc, CR_BYTE);
            end else begin
                n_pending = 1'b1;
            end
        end else if (!by_feed) begin
            n_match = sep_next(n_match, i_step.data);
            n_esc   = esc_next(n_esc, i_step.data);
        end

        o_result.is_separator = by_feed && (n_match == SEP_DONE);
        o_result.new_message  = o_result.is_separator && r_seen;
        o_result.escaped_from = (n_esc == ESC_DONE);

        if (o_produce) begin
            n_seen  = 1'b1;
            n_match = SEP_START;
            n_esc   = ESC_START;
        end
        // End of folder: the next byte starts a fresh folder.
        if (i_step.last) begin
            n_seen    = 1'b0;
            n_pending = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match   <= SEP_START;
            r_esc     <= ESC_START;
            r_seen    <= 1'b0;
            r_pending <= 1'b0;
        end else if (i_fire) begin
            r_match   <= n_match;
            r_esc     <= n_esc;
            r_seen    <= n_seen;
            r_pending <= n_pending;
        end
    end

endmodule

FILE: hdl/mbox_separator_line_classifier.sv
// Top level of the mbox separator line classifier: input register, line
// matcher and result register. Depends on mslc_pkg, mslc_line_matcher and
// the assertion macro header.
//
// Usage: the folder enters one byte per transaction on the s_axis channel,
// with s_axis_tlast marking the final byte of the folder. Each finished line
// (at a line feed, or at the final byte) gives one transaction on m_axis
// carrying is_separator, new_message and escaped_from. Bytes that end no
// line give no output. A carriage return directly before a line feed is
// dropped.
// Path: a line-ending byte is held in the input register, classified by the
// matcher, and its result is held in the result register, which offers it on
// m_axis. Throughput: one byte per cycle while no line-ending byte waits
// behind a result that the receiver has not yet taken.
// Reset (synchronous, active low) empties both registers and puts the line
// state at the start of a new folder. When the receiver stalls, the result
// is held; one more byte can sit in the input register, and bytes that end
// no line keep flowing past a waiting result.
`include "mbox_separator_line_classifier_macros.svh"

module mbox_separator_line_classifier
    import mslc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] line_byte
    input  logic       s_axis_tlast,   // stream_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] is_separator, [1] new_message,
                                       // [2] escaped_from, [7:3] zero
);

    logic    r_in_valid;
    t_step   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic    out_free;
    logic    produce;
    logic    advance;
    t_result result;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && (out_free || !produce);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.data <= s_axis_tdata;
            r_in.last <= s_axis_tlast;
        end
    end

    mslc_line_matcher u_matcher (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (r_in),
        .i_fire    (advance),
        .o_produce (produce),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && produce) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.escaped_from, r_out.new_message, r_out.is_separator};

    // A result never overwrites one that is still waiting.
    `MSLC_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, advance && produce, out_free)
    // The final byte of a folder always closes a line.
    `MSLC_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, advance && r_in.last, r_out_valid)
    // A new message is only ever reported on a separator line.
    `MSLC_ASSERT_NOW(a_new_needs_sep, i_clk, i_rst_n, r_out_valid && r_out.new_message,
                     r_out.is_separator)

endmodule
